// ===== rtl/csv_field_tokenizer_assert.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define CSVTOK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSVTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/csvtok_pkg.sv =====
`default_nettype none

package csvtok_pkg;

  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] DELIM_DEFAULT = 8'h2C;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_e;

  typedef enum logic {
    MODE_TEXT = 1'b0,
    MODE_EOT  = 1'b1
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/csvtok_req_if.sv =====
`default_nettype none

interface csvtok_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_byte;

  modport source (output valid, output mode, output char_byte, input ready);
  modport sink   (input valid, input mode, input char_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/csvtok_res_if.sv =====
`default_nettype none

interface csvtok_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/csv_field_tokenizer.sv =====
// The result of an accepted request is registered in the output register, or in the skid entry when stalled.
// Throughput: one request per cycle; a request is taken while the output waits,
// with one skid entry behind the output register; ready drops only when it is full.
// Requests that cause no result (opening quote, swallowed LF, blank line) are accepted and push nothing.
// Reset clears all parser flags and both result entries; delimiter returns to comma.
`default_nettype none

`include "csv_field_tokenizer_assert.svh"

module csv_field_tokenizer
  import csvtok_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  csvtok_req_if.sink       req_i,
  csvtok_res_if.source     res_o
);

  logic [7:0] delim_q;
  logic       in_quoted_q, in_quoted_d;
  logic       quote_pend_q, quote_pend_d;
  logic       cr_pend_q, cr_pend_d;
  logic       has_data_q, has_data_d;
  logic       row_open_q, row_open_d;

  logic       out_valid_q;
  result_t    out_q;
  logic       skid_valid_q;
  result_t    skid_q;

  logic       acc;
  logic       pop;
  logic       push;
  logic       unq;
  result_t    res;
  logic [7:0] b;

  assign req_i.ready = !skid_valid_q;
  assign acc         = req_i.valid && req_i.ready;
  assign pop         = out_valid_q && res_o.ready;
  assign b           = req_i.char_byte;

  assign res_o.valid = out_valid_q;
  assign res_o.kind  = out_q.kind;
  assign res_o.value = out_q.value;

  always_comb begin
    in_quoted_d  = in_quoted_q;
    quote_pend_d = quote_pend_q;
    cr_pend_d    = cr_pend_q;
    has_data_d   = has_data_q;
    row_open_d   = row_open_q;
    push         = 1'b0;
    unq          = 1'b0;
    res.kind     = KIND_BYTE;
    res.value    = 8'h00;
    if (acc) begin
      if (mode_e'(req_i.mode) == MODE_EOT) begin
        push         = row_open_q || has_data_q;
        res.kind     = KIND_ROW;
        in_quoted_d  = 1'b0;
        quote_pend_d = 1'b0;
        cr_pend_d    = 1'b0;
        has_data_d   = 1'b0;
        row_open_d   = 1'b0;
      end else begin
        cr_pend_d = 1'b0;
        if (!(cr_pend_q && b == CH_LF)) begin
          if (in_quoted_q) begin
            if (quote_pend_q) begin
              quote_pend_d = 1'b0;
              if (b == CH_QUOTE) begin
                push       = 1'b1;
                res.value  = CH_QUOTE;
                has_data_d = 1'b1;
              end else begin
                in_quoted_d = 1'b0;
                unq         = 1'b1;
              end
            end else if (b == CH_QUOTE) begin
              quote_pend_d = 1'b1;
            end else begin
              push       = 1'b1;
              res.value  = b;
              has_data_d = 1'b1;
            end
          end else begin
            unq = 1'b1;
          end
          if (unq) begin
            if (b == CH_QUOTE && !has_data_q) begin
              in_quoted_d = 1'b1;
              row_open_d  = 1'b1;
            end else if (b == delim_q) begin
              push       = 1'b1;
              res.kind   = KIND_FIELD;
              has_data_d = 1'b0;
              row_open_d = 1'b1;
            end else if (b == CH_LF || b == CH_CR) begin
              cr_pend_d  = (b == CH_CR);
              push       = row_open_q || has_data_q;
              res.kind   = KIND_ROW;
              has_data_d = 1'b0;
              row_open_d = 1'b0;
            end else begin
              push       = 1'b1;
              res.value  = b;
              has_data_d = 1'b1;
              row_open_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q      <= DELIM_DEFAULT;
      in_quoted_q  <= 1'b0;
      quote_pend_q <= 1'b0;
      cr_pend_q    <= 1'b0;
      has_data_q   <= 1'b0;
      row_open_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
      in_quoted_q  <= in_quoted_d;
      quote_pend_q <= quote_pend_d;
      cr_pend_q    <= cr_pend_d;
      has_data_q   <= has_data_d;
      row_open_q   <= row_open_d;
    end
  end

  // advance output register from skid or new result; park in skid when stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q  <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  `CSVTOK_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `CSVTOK_ASSERT_NOW(a_marker_zero, out_valid_q && out_q.kind != KIND_BYTE,
                     out_q.value == 8'h00, "field or row end carries nonzero value")
  `CSVTOK_ASSERT_NOW(a_quote_in_quotes, quote_pend_q, in_quoted_q,
                     "quote pending outside quoted field")
  `CSVTOK_ASSERT_NEXT(a_eot_clears, acc && req_i.mode == MODE_EOT,
                      !in_quoted_q && !quote_pend_q && !cr_pend_q && !has_data_q && !row_open_q,
                      "end of text left parser state set")

endmodule

`default_nettype wire
